// ===== rtl/core/height_color_ramp_macros.svh =====
// assertion macros for the height color ramp rtl
`ifndef HEIGHT_COLOR_RAMP_MACROS_SVH
`define HEIGHT_COLOR_RAMP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define HCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequence checked in the cycle after the antecedent
`define HCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/hcr_pkg.sv =====
// types and constants of the height color ramp
`timescale 1ns / 1ps
package hcr_pkg;

	localparam int HEIGHT_BITS = 16;
	localparam int COLOR_W     = 24;
	localparam int CHAN_W      = 8;
	localparam int NCHAN       = 3;
	localparam int MAXH_W      = 15;
	localparam int MINH_W      = 16;
	localparam int CMP_W       = (HEIGHT_BITS > MINH_W) ? HEIGHT_BITS : MINH_W;
	localparam int PIX_W       = 15;
	localparam int LEN_W       = 16;
	localparam int DEN_W       = LEN_W + 1;
	localparam int MAG_W       = PIX_W + CHAN_W;
	localparam int REM_W       = MAG_W + 2;
	localparam int IN_W        = ((HEIGHT_BITS + COLOR_W + 7) / 8) * 8;
	localparam int IDX_W       = 3;
	// stage of the first division register, and of the output register
	localparam int DIV_BASE    = 4;
	localparam int NSTG        = DIV_BASE + CHAN_W + 1;

	typedef enum logic [IDX_W-1:0] {
		REG_MAX_HEIGHT,
		REG_MIN_HEIGHT,
		REG_TOP_COLOR,
		REG_BASE_COLOR,
		REG_BOTTOM_COLOR,
		REG_FALLBACK_COLOR
	} reg_idx_t;

	localparam logic [COLOR_W-1:0] TOP_COLOR_RST    = 24'hFF00FF;
	localparam logic [COLOR_W-1:0] BASE_COLOR_RST   = 24'hFFFFFF;
	localparam logic [COLOR_W-1:0] BOTTOM_COLOR_RST = 24'h00FF00;

	typedef logic [NCHAN-1:0][CHAN_W-1:0] chans_t;

	// color holds the start color of a blend, else the final color
	typedef struct packed {
		logic               blend;
		logic [COLOR_W-1:0] color;
		logic [NCHAN-1:0]   neg;
		logic [DEN_W-1:0]   den2;
	} item_t;

	typedef struct packed {
		logic [NCHAN-1:0][REM_W-1:0]  rem;
		logic [NCHAN-1:0][CHAN_W-1:0] quo;
	} quot_t;

endpackage

// ===== rtl/core/height_color_ramp.sv =====
// height color ramp: per-point color from explicit color or height gradient
//
//   channel   direction  handshake                 content
//   s_*       in         s_tvalid / s_tready       height, explicit color
//   m_*       out        m_tvalid / m_tready       point color
//   cfg_*     in         cfg_valid / cfg_ready     register index, write data
//
// one word per cycle sustained while m_tready stays high; 13 register stages, the output
// register (stage 13) loads an accepted word once it has passed through stages 1 to 12
// most stages belong to the restoring divider, one quotient bit per stage, 8 stages
// reset clears the stage valid bits and loads the register reset colors
// a stalled output holds its word; earlier stages keep filling bubbles, and each
// stops only when it and every later stage are occupied
`timescale 1ns / 1ps
`include "height_color_ramp_macros.svh"

module height_color_ramp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [hcr_pkg::IN_W-1:0]    s_tdata,    // height, explicit_color
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [hcr_pkg::COLOR_W-1:0] m_tdata,    // point_color
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hcr_pkg::IDX_W-1:0]   cfg_index,
	input  logic [hcr_pkg::COLOR_W-1:0] cfg_data
);
	import hcr_pkg::*;

	localparam int FIN = DIV_BASE + CHAN_W;

	logic [MAXH_W-1:0]        max_height_q;
	logic signed [MINH_W-1:0] min_height_q;
	logic [COLOR_W-1:0]       top_color_q;
	logic [COLOR_W-1:0]       base_color_q;
	logic [COLOR_W-1:0]       bottom_color_q;

	logic signed [MINH_W-1:0] hi_c;
	logic signed [MINH_W-1:0] lo_c;

	logic [NSTG:1]   vld_s;
	logic [NSTG+1:1] ld;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_height_q   <= '0;
			min_height_q   <= '0;
			top_color_q    <= TOP_COLOR_RST;
			base_color_q   <= BASE_COLOR_RST;
			bottom_color_q <= BOTTOM_COLOR_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_HEIGHT:     max_height_q   <= cfg_data[MAXH_W-1:0];
				REG_MIN_HEIGHT:     min_height_q   <= cfg_data[MINH_W-1:0];
				REG_TOP_COLOR:      top_color_q    <= cfg_data;
				REG_BASE_COLOR:     base_color_q   <= cfg_data;
				REG_BOTTOM_COLOR:   bottom_color_q <= cfg_data;
				// the color rules always override the fallback, nothing to keep
				REG_FALLBACK_COLOR: ;
				default: ;
			endcase
		end
	end

	assign hi_c = {1'b0, max_height_q};
	assign lo_c = (min_height_q > 0) ? '0 : min_height_q;

	// stage load enables, ready travels back from the output register
	always_comb begin
		ld[NSTG+1] = m_tready;
		for (int k = NSTG; k >= 1; k--) begin
			ld[k] = !vld_s[k] || ld[k+1];
		end
	end

	assign s_tready = ld[1];
	assign m_tvalid = vld_s[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[1]) begin
				vld_s[1] <= s_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// stage 1: clamp the height into the configured range
	logic signed [HEIGHT_BITS-1:0] h_in;
	logic signed [CMP_W-1:0]       h_x;
	logic signed [CMP_W-1:0]       hi_x;
	logic signed [CMP_W-1:0]       lo_x;
	logic signed [MINH_W-1:0]      h_cl;
	logic signed [MINH_W-1:0]      h_s1;
	logic [COLOR_W-1:0]            expl_s1;

	always_comb begin
		h_in = s_tdata[HEIGHT_BITS-1:0];
		h_x  = CMP_W'(h_in);
		hi_x = CMP_W'(hi_c);
		lo_x = CMP_W'(lo_c);
		if (h_x > hi_x) begin
			h_cl = hi_c;
		end else if (h_x < lo_x) begin
			h_cl = lo_c;
		end else begin
			h_cl = h_x[MINH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			h_s1    <= h_cl;
			expl_s1 <= s_tdata[HEIGHT_BITS +: COLOR_W];
		end
	end

	// stage 2: pick the rule, blend operands and per-channel differences
	item_t            item_c2;
	logic [PIX_W-1:0] pix_c2;
	chans_t           absd_c2;
	item_t            item_s2;
	logic [PIX_W-1:0] pix_s2;
	chans_t           absd_s2;

	always_comb begin
		logic                 is_expl;
		logic                 at_top;
		logic                 at_zero;
		logic                 at_bot;
		logic                 pos;
		logic [COLOR_W-1:0]   end_c;
		logic [MINH_W:0]      h_lo;
		logic [MINH_W:0]      neg_lo;
		logic [LEN_W-1:0]     len;
		chans_t               st;
		chans_t               en;

		is_expl = (expl_s1 != '0);
		at_top  = (h_s1 == hi_c);
		at_zero = (h_s1 == '0);
		at_bot  = (h_s1 == lo_c) && (lo_c != '0);
		pos     = !h_s1[MINH_W-1];
		h_lo    = {h_s1[MINH_W-1], h_s1} - {lo_c[MINH_W-1], lo_c};
		neg_lo  = '0 - {lo_c[MINH_W-1], lo_c};

		item_c2.blend = !is_expl && !at_top && !at_zero && !at_bot;
		if (is_expl) begin
			item_c2.color = expl_s1;
		end else if (at_top) begin
			item_c2.color = top_color_q;
		end else if (at_zero) begin
			item_c2.color = base_color_q;
		end else if (at_bot) begin
			item_c2.color = bottom_color_q;
		end else if (pos) begin
			item_c2.color = base_color_q;
		end else begin
			item_c2.color = bottom_color_q;
		end

		end_c  = pos ? top_color_q : base_color_q;
		pix_c2 = pos ? h_s1[PIX_W-1:0] : h_lo[PIX_W-1:0];
		len    = pos ? {1'b0, max_height_q} : neg_lo[LEN_W-1:0];
		item_c2.den2 = {len, 1'b0};

		st = chans_t'(item_c2.color);
		en = chans_t'(end_c);
		for (int c = 0; c < NCHAN; c++) begin
			item_c2.neg[c] = (en[c] < st[c]);
			absd_c2[c]     = item_c2.neg[c] ? (st[c] - en[c]) : (en[c] - st[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			item_s2 <= item_c2;
			pix_s2  <= pix_c2;
			absd_s2 <= absd_c2;
		end
	end

	// stage 3: magnitude of pixel times difference
	item_t                      item_s3;
	logic [NCHAN-1:0][MAG_W-1:0] mag_s3;

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			item_s3 <= item_s2;
			for (int c = 0; c < NCHAN; c++) begin
				mag_s3[c] <= MAG_W'(pix_s2) * MAG_W'(absd_s2[c]);
			end
		end
	end

	// stages 4 to 12: pipe_s[k] and div_s[k] sit in stage DIV_BASE + k
	// dividend 2*mag + len over 2*len rounds the quotient half away from zero
	item_t pipe_s [0:CHAN_W];
	quot_t div_s  [0:CHAN_W];

	always_ff @(posedge clk) begin
		if (ld[DIV_BASE]) begin
			pipe_s[0] <= item_s3;
			for (int c = 0; c < NCHAN; c++) begin
				div_s[0].rem[c] <= REM_W'({mag_s3[c], 1'b0})
					+ REM_W'(item_s3.den2[DEN_W-1:1]);
				div_s[0].quo[c] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= CHAN_W; k++) begin : g_div
		quot_t nxt;

		// one quotient bit per stage, most significant first
		always_comb begin
			logic [REM_W:0] sub;
			nxt = div_s[k-1];
			for (int c = 0; c < NCHAN; c++) begin
				sub = (REM_W+1)'(div_s[k-1].rem[c])
					- ((REM_W+1)'(pipe_s[k-1].den2) << (CHAN_W - k));
				if (!sub[REM_W]) begin
					nxt.rem[c]              = sub[REM_W-1:0];
					nxt.quo[c][CHAN_W - k]  = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ld[DIV_BASE + k]) begin
				div_s[k]  <= nxt;
				pipe_s[k] <= pipe_s[k-1];
			end
		end
	end

	// output stage: apply the sign and add the start color, or pass the final color when not blending
	chans_t             blend_c;
	logic [COLOR_W-1:0] color_s13;
	logic               chan_ovf;
	logic               rem_ok;

	always_comb begin
		chans_t        st;
		logic [CHAN_W:0] sum;
		st       = chans_t'(pipe_s[CHAN_W].color);
		chan_ovf = 1'b0;
		rem_ok   = 1'b1;
		for (int c = 0; c < NCHAN; c++) begin
			if (pipe_s[CHAN_W].neg[c]) begin
				sum = {1'b0, st[c]} - {1'b0, div_s[CHAN_W].quo[c]};
			end else begin
				sum = {1'b0, st[c]} + {1'b0, div_s[CHAN_W].quo[c]};
			end
			blend_c[c] = sum[CHAN_W-1:0];
			chan_ovf   = chan_ovf | sum[CHAN_W];
			rem_ok     = rem_ok && (div_s[CHAN_W].rem[c] < REM_W'(pipe_s[CHAN_W].den2));
		end
	end

	always_ff @(posedge clk) begin
		if (ld[NSTG]) begin
			color_s13 <= pipe_s[CHAN_W].blend ? COLOR_W'(blend_c) : pipe_s[CHAN_W].color;
		end
	end

	assign m_tdata = color_s13;

	// checks
	`HCR_ASSERT(a_ready_low_only_full, !s_tready |-> (m_tvalid && !m_tready), "input stalled with room in the pipeline")
	`HCR_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, vld_s[1], "accepted word missing from stage 1")
	`HCR_ASSERT(a_blend_len_nonzero, (vld_s[3] && item_s3.blend) |-> (item_s3.den2 != '0), "blend with zero length")
	`HCR_ASSERT(a_div_rem_small, (vld_s[FIN] && pipe_s[CHAN_W].blend) |-> rem_ok, "division remainder not below divisor")
	`HCR_ASSERT(a_chan_no_wrap, (vld_s[FIN] && pipe_s[CHAN_W].blend) |-> !chan_ovf, "blended channel out of range")

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the height color ramp: directed plan, random points, live prediction
`timescale 1ns / 1ps

module tb_top;
	import hcr_pkg::*;

	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT  = 2000;
	localparam int SEGMENTS     = 6;
	localparam int SEG_POINTS   = 330;

	typedef struct {
		bit          wr;
		reg_idx_t    idx;
		logic [23:0] val;
		logic [15:0] height;
		bit          known;
		logic [23:0] color;
	} step_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [COLOR_W-1:0]  m_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [COLOR_W-1:0]  cfg_data = '0;

	// typed-in color for a directed point, travels with the word
	logic                word_ref_known = 1'b0;
	logic [23:0]         word_ref_color = '0;

	// register copy
	logic [14:0]         cur_max = '0;
	logic signed [15:0]  cur_min = '0;
	logic [23:0]         cur_top = TOP_COLOR_RST;
	logic [23:0]         cur_base = BASE_COLOR_RST;
	logic [23:0]         cur_bottom = BOTTOM_COLOR_RST;

	logic [23:0]         color_due[$];
	int                  err_count = 0;
	int                  stall_cycles = 0;
	int                  src_idle = 0;
	int                  snk_idle = 0;
	step_t               plan[$];

	height_color_ramp dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// per-channel blend, rounded half away from zero
	function automatic logic [23:0] mix_channels(input logic [23:0] from_c,
			input logic [23:0] to_c, input longint span, input longint pos);
		logic [23:0] res;
		longint s, e, num, mag, q, c;
		int k;
		if (span <= 0)
			return from_c;
		res = '0;
		for (k = 0; k < 3; k++) begin
			s = from_c[8*k +: 8];
			e = to_c[8*k +: 8];
			num = pos * (e - s);
			mag = (num < 0) ? -num : num;
			q = (2 * mag + span) / (2 * span);
			if (num < 0)
				q = -q;
			c = s + q;
			res[8*k +: 8] = c[7:0];
		end
		return res;
	endfunction

	function automatic logic [23:0] ramp_color(input logic [15:0] h16, input logic [23:0] expl);
		logic signed [15:0] hs;
		longint h, hi, lo;
		hs = h16;
		h = hs;
		hi = cur_max;
		if (cur_min > 0)
			lo = 0;
		else
			lo = cur_min;
		if (h > hi)
			h = hi;
		if (h < lo)
			h = lo;
		if (expl != 0)
			return expl;
		if (h == hi)
			return cur_top;
		if (h == 0)
			return cur_base;
		if (h == lo && lo != 0)
			return cur_bottom;
		if (h > 0)
			return mix_channels(cur_base, cur_top, hi, h);
		return mix_channels(cur_bottom, cur_base, -lo, h - lo);
	endfunction

	task automatic flag_error(input string what, input logic [23:0] want, input logic [23:0] got);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s expected %06h got %06h", $time, what, want, got);
	endtask

	// output check, expectation capture, register copy, watchdog
	always @(posedge clk) begin
		logic [23:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (color_due.size() == 0) begin
					flag_error("unexpected word", 'x, m_tdata);
				end else begin
					want = color_due.pop_front();
					if (m_tdata !== want)
						flag_error("point_color", want, m_tdata);
				end
			end
			if (s_tvalid && s_tready)
				color_due.push_back(word_ref_known ? word_ref_color :
					ramp_color(s_tdata[15:0], s_tdata[39:16]));
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_MAX_HEIGHT:   cur_max = cfg_data[14:0];
					REG_MIN_HEIGHT:   cur_min = cfg_data[15:0];
					REG_TOP_COLOR:    cur_top = cfg_data;
					REG_BASE_COLOR:   cur_base = cfg_data;
					REG_BOTTOM_COLOR: cur_bottom = cfg_data;
					default: ;  // fallback color never reaches the output
				endcase
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("height_color_ramp test failed");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle);
	end

	task automatic send_point(input logic [15:0] h, input logic [23:0] expl,
			input bit known, input logic [23:0] color);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {expl, h};
		word_ref_known <= known;
		word_ref_color <= color;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait for every expected color, then let the pipe settle
	task automatic wait_idle(input int extra);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (color_due.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic step_t wr_step(input reg_idx_t idx, input logic [23:0] val);
		step_t st;
		st = '{wr: 1'b1, idx: idx, val: val, height: '0, known: 1'b0, color: '0};
		return st;
	endfunction

	function automatic step_t pt_step(input logic [15:0] h, input logic [23:0] expl,
			input bit known, input logic [23:0] color);
		step_t st;
		st = '{wr: 1'b0, idx: REG_MAX_HEIGHT, val: expl, height: h, known: known, color: color};
		return st;
	endfunction

	function automatic logic [23:0] pick_color();
		case ($urandom_range(7))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_config();
		logic [15:0] mn;
		case ($urandom_range(4))
			0: write_reg(REG_MAX_HEIGHT, 24'd0);
			1: write_reg(REG_MAX_HEIGHT, 24'd1);
			2: write_reg(REG_MAX_HEIGHT, 24'd32767);
			3: write_reg(REG_MAX_HEIGHT, 24'($urandom_range(2, 300)));
			default: write_reg(REG_MAX_HEIGHT, 24'($urandom_range(2, 32766)));
		endcase
		case ($urandom_range(5))
			0: mn = 16'h0000;
			1: mn = 16'hFFFF;
			2: mn = 16'h8000;
			3: mn = 16'(-$urandom_range(2, 300));
			4: mn = 16'($urandom_range(1, 32767));  // positive minimum acts as zero
			default: mn = 16'(-$urandom_range(2, 32767));
		endcase
		write_reg(REG_MIN_HEIGHT, {8'h00, mn});
		write_reg(REG_TOP_COLOR, pick_color());
		write_reg(REG_BASE_COLOR, pick_color());
		write_reg(REG_BOTTOM_COLOR, pick_color());
		write_reg(REG_FALLBACK_COLOR, pick_color());
	endtask

	function automatic logic [15:0] pick_height();
		int lo, hi;
		lo = (cur_min > 0) ? 0 : int'(cur_min);
		hi = cur_max;
		case ($urandom_range(9))
			0, 1: return 16'($urandom);
			2: begin
				case ($urandom_range(7))
					0: return 16'(hi);
					1: return 16'(lo);
					2: return 16'h0000;
					3: return 16'(hi + 1);
					4: return 16'(lo - 1);
					5: return 16'h7FFF;
					6: return 16'h8000;
					default: return $urandom_range(1) ? 16'h0001 : 16'hFFFF;
				endcase
			end
			default: return 16'(lo + int'($urandom_range(hi - lo)));
		endcase
	endfunction

	initial begin
		bit          prev_point;
		logic [15:0] h;
		logic [23:0] expl;
		int          seg, n;

		// reset values: max and min both zero, so every plain point is top color
		plan.push_back(pt_step(16'h0000, 24'h000000, 1, 24'hFF00FF));
		plan.push_back(pt_step(16'h7FFF, 24'h000000, 1, 24'hFF00FF));
		plan.push_back(pt_step(16'h8000, 24'h000000, 1, 24'hFF00FF));
		plan.push_back(pt_step(16'h0005, 24'hFFFFFF, 1, 24'hFFFFFF));
		plan.push_back(pt_step(16'hFFFF, 24'h000001, 1, 24'h000001));
		// full height range
		plan.push_back(wr_step(REG_MAX_HEIGHT, 24'd32767));
		plan.push_back(wr_step(REG_MIN_HEIGHT, 24'h008000));
		plan.push_back(wr_step(REG_TOP_COLOR, 24'h000000));
		plan.push_back(wr_step(REG_BASE_COLOR, 24'h80C040));
		plan.push_back(wr_step(REG_BOTTOM_COLOR, 24'hFFFFFF));
		plan.push_back(wr_step(REG_FALLBACK_COLOR, 24'h123456));
		plan.push_back(pt_step(16'h7FFF, 24'h000000, 1, 24'h000000));
		plan.push_back(pt_step(16'h0000, 24'h000000, 1, 24'h80C040));
		plan.push_back(pt_step(16'h8000, 24'h000000, 1, 24'hFFFFFF));
		plan.push_back(pt_step(16'h0001, 24'h000000, 0, '0));
		plan.push_back(pt_step(16'h4000, 24'h000000, 0, '0));
		plan.push_back(pt_step(16'h7FFE, 24'h000000, 0, '0));
		plan.push_back(pt_step(16'hFFFF, 24'h000000, 0, '0));
		plan.push_back(pt_step(16'hC000, 24'h000000, 0, '0));
		plan.push_back(pt_step(16'h8001, 24'h000000, 0, '0));
		plan.push_back(pt_step(16'h1234, 24'h800000, 1, 24'h800000));
		// short range, clamping on both sides, half-way rounding
		plan.push_back(wr_step(REG_MAX_HEIGHT, 24'd100));
		plan.push_back(wr_step(REG_MIN_HEIGHT, 24'h00FF9C));
		plan.push_back(wr_step(REG_TOP_COLOR, 24'h00FF01));
		plan.push_back(wr_step(REG_BASE_COLOR, 24'hFF0000));
		plan.push_back(wr_step(REG_BOTTOM_COLOR, 24'h0000FF));
		plan.push_back(pt_step(16'd200, 24'h000000, 1, 24'h00FF01));
		plan.push_back(pt_step(-16'sd200, 24'h000000, 1, 24'h0000FF));
		plan.push_back(pt_step(16'd50, 24'h000000, 0, '0));
		plan.push_back(pt_step(-16'sd50, 24'h000000, 0, '0));
		plan.push_back(pt_step(16'd99, 24'h000000, 0, '0));
		// positive minimum behaves as zero
		plan.push_back(wr_step(REG_MIN_HEIGHT, 24'd5));
		plan.push_back(pt_step(-16'sd50, 24'h000000, 1, 24'hFF0000));
		// zero maximum: positive heights clamp to zero and hit the top rule first
		plan.push_back(wr_step(REG_MAX_HEIGHT, 24'd0));
		plan.push_back(pt_step(16'd50, 24'h000000, 1, 24'h00FF01));
		// one-step range on each side
		plan.push_back(wr_step(REG_MIN_HEIGHT, 24'h00FFFF));
		plan.push_back(wr_step(REG_MAX_HEIGHT, 24'd1));
		plan.push_back(pt_step(16'd1, 24'h000000, 1, 24'h00FF01));
		plan.push_back(pt_step(16'hFFFF, 24'h000000, 1, 24'h0000FF));
		plan.push_back(pt_step(-16'sd5, 24'h000000, 1, 24'h0000FF));
		plan.push_back(pt_step(16'h0000, 24'h000000, 1, 24'hFF0000));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 8;
		snk_idle = 60;
		prev_point = 0;
		foreach (plan[i]) begin
			if (plan[i].wr) begin
				if (prev_point)
					wait_idle(DRAIN_CYCLES);
				write_reg(plan[i].idx, plan[i].val);
				prev_point = 0;
			end else begin
				send_point(plan[i].height, plan[i].val, plan[i].known, plan[i].color);
				prev_point = 1;
			end
		end

		for (seg = 0; seg < SEGMENTS; seg++) begin
			wait_idle(DRAIN_CYCLES);
			random_config();
			case (seg / 2)
				0: begin src_idle = 8;  snk_idle = 60; end
				1: begin src_idle = 60; snk_idle = 8;  end
				default: begin src_idle = 0; snk_idle = 0; end
			endcase
			for (n = 0; n < SEG_POINTS; n++) begin
				h = pick_height();
				expl = ($urandom_range(99) < 65) ? 24'h000000 : 24'($urandom);
				send_point(h, expl, 0, '0);
				if ($urandom_range(149) == 0)
					wait_idle(0);
			end
		end

		wait_idle(DRAIN_CYCLES);
		if (err_count == 0 && color_due.size() == 0) begin
			$display("height_color_ramp test passed");
		end else begin
			$display("height_color_ramp test failed");
		end
		$finish;
	end

endmodule
